/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

/* src/orfc_pkg.sv */
// Shared types and constants of the open reading frame checker.
package orfc_pkg;

  localparam int BASE_BITS      = 3;
  localparam int VERDICT_BITS   = 3;
  localparam int OUT_COUNT_BITS = 24;

  localparam logic [BASE_BITS-1:0] BASE_A     = 3'd0;
  localparam logic [BASE_BITS-1:0] BASE_C     = 3'd1;
  localparam logic [BASE_BITS-1:0] BASE_G     = 3'd2;
  localparam logic [BASE_BITS-1:0] BASE_T     = 3'd3;
  localparam logic [BASE_BITS-1:0] BASE_OTHER = 3'd4;

  localparam logic [VERDICT_BITS-1:0] VERDICT_OK         = 3'd0;
  localparam logic [VERDICT_BITS-1:0] VERDICT_BAD_LENGTH = 3'd1;
  localparam logic [VERDICT_BITS-1:0] VERDICT_BAD_START  = 3'd2;
  localparam logic [VERDICT_BITS-1:0] VERDICT_INT_STOP   = 3'd3;
  localparam logic [VERDICT_BITS-1:0] VERDICT_BAD_END    = 3'd4;

  // Codon phase: bases of the current codon already seen.
  localparam logic [1:0] PHASE_ZERO = 2'd0;
  localparam logic [1:0] PHASE_TWO  = 2'd2;

  // Classification of one three-base window.
  typedef struct packed {
    logic atg;        // a t g
    logic stop_any;   // taa, tag or tga
    logic stop_no_tga; // taa or tag
  } codon_class_t;

endpackage

/* src/open_reading_frame_checker.sv */
// Top level of the open reading frame checker: region state and result register.
//
// Usage:
//   Input channel (in_valid/in_ready): one base per request, with first and
//   last marking the coding region. The region flags (start_complete,
//   end_complete, selenocysteine, alt_start_ok) are sampled on first.
//   Result channel (out_valid/out_ready): one verdict per region, produced
//   for the request that carries last: verdict, codon_count, begins_atg,
//   ends_stop.
//   Latency: the result is valid in the cycle after the last base is taken.
//   Throughput: one base per cycle while in_ready is high; the region state
//   updates in one pass from the registered state and the incoming base.
//   Stalls: the result register holds a finished verdict until out_ready;
//   while it is full and not being drained, in_ready is low. Taking the
//   result and a new base in the same cycle is allowed.
//   Reset (rst_n low, synchronous): region state, region flags and the
//   result valid flag are cleared (the payload is not); no result is pending.
//   The codon counter is CODON_COUNT_BITS wide and saturates at its top;
//   codon_count is the counter, clipped to its 24-bit top when the counter is wider.
module open_reading_frame_checker
  import orfc_pkg::*;
#(
  parameter int CODON_COUNT_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [BASE_BITS-1:0]      in_base,
  input  logic                      in_first,
  input  logic                      in_last,
  input  logic                      in_start_complete,
  input  logic                      in_end_complete,
  input  logic                      in_selenocysteine,
  input  logic                      in_alt_start_ok,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [VERDICT_BITS-1:0]   out_verdict,
  output logic [OUT_COUNT_BITS-1:0] out_codon_count,
  output logic                      out_begins_atg,
  output logic                      out_ends_stop
);

  localparam int CW = CODON_COUNT_BITS;

  // Region state
  logic [BASE_BITS-1:0] b0_r, b1_r;   // b0 newest
  logic [1:0]           phase_r;
  logic [CW-1:0]        cnt_r;
  logic                 atg_r;
  logic                 prior_stop_r;
  logic                 seen_r;
  logic                 f_start_r, f_end_r, f_sec_r, f_alt_r;

  // Result register
  logic                      out_valid_r;
  logic [VERDICT_BITS-1:0]   verdict_r;
  logic [OUT_COUNT_BITS-1:0] count_r;
  logic                      begins_r;
  logic                      ends_r;

  logic accept;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Effective current state: a first base starts from a cleared region.
  logic [BASE_BITS-1:0] b_in, eb0, eb1;
  logic [1:0]           ephase;
  logic [CW-1:0]        ecnt;
  logic                 eatg, eprior, eseen;
  logic                 f_start_nxt, f_end_nxt, f_sec_nxt, f_alt_nxt;

  // Codes above the last defined one all read as "other".
  assign b_in   = (in_base > BASE_OTHER) ? BASE_OTHER : in_base;
  assign eb0    = in_first ? BASE_A : b0_r;
  assign eb1    = in_first ? BASE_A : b1_r;
  assign ephase = in_first ? PHASE_ZERO : phase_r;
  assign ecnt   = in_first ? '0 : cnt_r;
  assign eatg   = in_first ? 1'b0 : atg_r;
  assign eprior = in_first ? 1'b0 : prior_stop_r;
  assign eseen  = in_first ? 1'b0 : seen_r;

  assign f_start_nxt = in_first ? in_start_complete : f_start_r;
  assign f_end_nxt   = in_first ? in_end_complete   : f_end_r;
  assign f_sec_nxt   = in_first ? in_selenocysteine : f_sec_r;
  assign f_alt_nxt   = in_first ? in_alt_start_ok   : f_alt_r;

  codon_class_t cls;

  orfc_codon_eval u_eval (
    .b_old (eb1),
    .b_mid (eb0),
    .b_new (b_in),
    .cls   (cls)
  );

  // Single-pass update
  logic          complete;
  logic [1:0]    phase_nxt;
  logic [CW-1:0] cnt_nxt;
  logic          atg_nxt, prior_nxt, seen_nxt;
  logic          ends_stop;
  logic          begins_atg;
  logic [VERDICT_BITS-1:0]   verdict;
  logic [OUT_COUNT_BITS-1:0] count_out;

  assign complete  = (ephase == PHASE_TWO);
  assign phase_nxt = complete ? PHASE_ZERO : ephase + 2'd1;
  assign cnt_nxt   = !complete ? ecnt :
                     ((ecnt == {CW{1'b1}}) ? ecnt : ecnt + CW'(1));
  assign atg_nxt   = (complete && (ecnt == '0)) ? cls.atg : eatg;
  assign seen_nxt  = eseen || (complete && eprior);
  assign prior_nxt = complete ? (f_sec_nxt ? cls.stop_no_tga : cls.stop_any) : eprior;

  // Last three bases, whatever the phase, once a codon has been counted.
  assign ends_stop  = (cnt_nxt != '0) && cls.stop_any;
  assign begins_atg = (cnt_nxt != '0) && atg_nxt;

  // First failing check wins.
  always_comb begin
    if (phase_nxt != PHASE_ZERO) begin
      verdict = VERDICT_BAD_LENGTH;
    end else if (f_start_nxt && !atg_nxt && !f_alt_nxt) begin
      verdict = VERDICT_BAD_START;
    end else if (seen_nxt) begin
      verdict = VERDICT_INT_STOP;
    end else if (f_end_nxt && !ends_stop) begin
      verdict = VERDICT_BAD_END;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  // Fit the internal counter onto the fixed output width.
  if (CW > OUT_COUNT_BITS) begin : g_cnt_sat
    assign count_out = (cnt_nxt[CW-1:OUT_COUNT_BITS] != '0) ?
                       {OUT_COUNT_BITS{1'b1}} : cnt_nxt[OUT_COUNT_BITS-1:0];
  end else begin : g_cnt_ext
    assign count_out = OUT_COUNT_BITS'(cnt_nxt);
  end

  // Region state; a last base clears everything but the flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r         <= BASE_A;
      b1_r         <= BASE_A;
      phase_r      <= PHASE_ZERO;
      cnt_r        <= '0;
      atg_r        <= 1'b0;
      prior_stop_r <= 1'b0;
      seen_r       <= 1'b0;
      f_start_r    <= 1'b0;
      f_end_r      <= 1'b0;
      f_sec_r      <= 1'b0;
      f_alt_r      <= 1'b0;
    end else if (accept) begin
      f_start_r <= f_start_nxt;
      f_end_r   <= f_end_nxt;
      f_sec_r   <= f_sec_nxt;
      f_alt_r   <= f_alt_nxt;
      if (in_last) begin
        b0_r         <= BASE_A;
        b1_r         <= BASE_A;
        phase_r      <= PHASE_ZERO;
        cnt_r        <= '0;
        atg_r        <= 1'b0;
        prior_stop_r <= 1'b0;
        seen_r       <= 1'b0;
      end else begin
        b0_r         <= b_in;
        b1_r         <= eb0;
        phase_r      <= phase_nxt;
        cnt_r        <= cnt_nxt;
        atg_r        <= atg_nxt;
        prior_stop_r <= prior_nxt;
        seen_r       <= seen_nxt;
      end
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      verdict_r <= verdict;
      count_r   <= count_out;
      begins_r  <= begins_atg;
      ends_r    <= ends_stop;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_verdict     = verdict_r;
  assign out_codon_count = count_r;
  assign out_begins_atg  = begins_r;
  assign out_ends_stop   = ends_r;

endmodule

/* src/orfc_codon_eval.sv */
// Classifies a three-base window as start codon and stop codon types.
module orfc_codon_eval
  import orfc_pkg::*;
(
  input  logic [BASE_BITS-1:0] b_old,
  input  logic [BASE_BITS-1:0] b_mid,
  input  logic [BASE_BITS-1:0] b_new,
  output codon_class_t         cls
);

  logic t_a;
  logic taa_tag;
  logic tga;

  assign t_a     = (b_old == BASE_T) && (b_mid == BASE_A);
  assign taa_tag = t_a && ((b_new == BASE_A) || (b_new == BASE_G));
  assign tga     = (b_old == BASE_T) && (b_mid == BASE_G) && (b_new == BASE_A);

  assign cls.atg         = (b_old == BASE_A) && (b_mid == BASE_T) && (b_new == BASE_G);
  assign cls.stop_any    = taa_tag || tga;
  assign cls.stop_no_tga = taa_tag;

endmodule

/* src/orfc_checker.sv */
// Port-level assertions for the open reading frame checker, bound to the top level.
`include "assert_macros.svh"

module orfc_checker
  import orfc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_last,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [VERDICT_BITS-1:0]   out_verdict,
  input logic [OUT_COUNT_BITS-1:0] out_codon_count
);

  logic out_stall;
  logic ok_verdict;

  assign out_stall  = out_valid && !out_ready;
  assign ok_verdict = out_valid && (out_verdict == VERDICT_OK);

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_verdict))
  `ASSERT_NEXT(a_count_hold, clk, rst_n, out_stall, $stable(out_codon_count))

  // Input back-pressure only comes from a pending result.
  `ASSERT_SAME(a_ready_src, clk, rst_n, !in_ready, out_stall)

  // A taken last base yields a result in the next cycle.
  `ASSERT_NEXT(a_last_result, clk, rst_n, in_valid && in_ready && in_last, out_valid)

  // An accepted region holds at least one whole codon.
  `ASSERT_SAME(a_ok_count, clk, rst_n, ok_verdict, out_codon_count != '0)

endmodule

bind open_reading_frame_checker orfc_checker u_orfc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last         (in_last),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_verdict     (out_verdict),
  .out_codon_count (out_codon_count)
);

/* tb/tb_open_reading_frame_checker.sv */
// Self-checking testbench for the open reading frame checker, with a built-in verdict predictor.
`timescale 1ns / 1ps

module tb_open_reading_frame_checker;
  import orfc_pkg::*;

  // Codon counter width of the instance; with 24 bits the output
  // saturation and the counter saturation coincide.
  localparam int CODON_BITS     = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 5;

  // Highest 3-bit code; codes above BASE_OTHER read like BASE_OTHER.
  localparam logic [BASE_BITS-1:0] BASE_CODE_MAX = 3'd7;

  // Region flag bits as they sit on a first base.
  localparam logic [3:0] RF_NONE  = 4'b0000;
  localparam logic [3:0] RF_START = 4'b0001;
  localparam logic [3:0] RF_END   = 4'b0010;
  localparam logic [3:0] RF_SEC   = 4'b0100;
  localparam logic [3:0] RF_ALT   = 4'b1000;
  localparam logic [3:0] RF_ALL   = 4'b1111;

  localparam logic [CODON_BITS-1:0]     CODON_MAX = '1;
  localparam logic [OUT_COUNT_BITS-1:0] OUT_MAX   = '1;

  typedef logic [BASE_BITS-1:0] base_seq_t[$];

  // Receiver behavior per phase.
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct {
    logic [VERDICT_BITS-1:0]   verdict;
    logic [OUT_COUNT_BITS-1:0] codons;
    logic                      begins_atg;
    logic                      ends_stop;
  } region_verdict_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [BASE_BITS-1:0]      in_base;
  logic                      in_first;
  logic                      in_last;
  logic                      in_start_complete;
  logic                      in_end_complete;
  logic                      in_selenocysteine;
  logic                      in_alt_start_ok;
  logic                      out_valid;
  logic                      out_ready;
  logic [VERDICT_BITS-1:0]   out_verdict;
  logic [OUT_COUNT_BITS-1:0] out_codon_count;
  logic                      out_begins_atg;
  logic                      out_ends_stop;

  open_reading_frame_checker #(
    .CODON_COUNT_BITS(CODON_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_base          (in_base),
    .in_first         (in_first),
    .in_last          (in_last),
    .in_start_complete(in_start_complete),
    .in_end_complete  (in_end_complete),
    .in_selenocysteine(in_selenocysteine),
    .in_alt_start_ok  (in_alt_start_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .out_codon_count  (out_codon_count),
    .out_begins_atg   (out_begins_atg),
    .out_ends_stop    (out_ends_stop)
  );

  // ---------------------------------------------------------------------
  // Clock and shared control
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  int       error_count = 0;
  int       idle_cycles = 0;
  bit       sender_gaps = 1'b0;   // bursts with gaps on the input side
  int       burst_left  = 0;
  rx_mode_t rx_mode     = RX_ALWAYS;
  int       rx_stall_pct = 0;     // stall odds in RX_RANDOM
  int       rx_period   = 7;      // RX_PATTERN: ready for rx_open of rx_period
  int       rx_open     = 4;
  int       rx_tick     = 0;
  bit       hold_req    = 1'b0;   // long receiver hold-off, cleared by the receiver

  region_verdict_t pending_verdicts[$];
  region_verdict_t head;

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the region state of the block
  // ---------------------------------------------------------------------
  logic [BASE_BITS-1:0]  hist_new   = BASE_A;   // newest previous base
  logic [BASE_BITS-1:0]  hist_old   = BASE_A;
  logic [1:0]            phase      = PHASE_ZERO;
  logic [CODON_BITS-1:0] codons     = '0;
  logic                  opens_atg  = 1'b0;
  logic                  prev_stop  = 1'b0;     // most recent codon was a stop
  logic                  stop_inside = 1'b0;    // a stop was followed by a codon
  logic [3:0]            held_flags = RF_NONE;

  function automatic bit codon_atg(logic [BASE_BITS-1:0] x, y, z);
    return x == BASE_A && y == BASE_T && z == BASE_G;
  endfunction

  // taa and tag always; tga only when with_tga is set
  function automatic bit codon_stop(logic [BASE_BITS-1:0] x, y, z, bit with_tga);
    if (x != BASE_T) return 1'b0;
    if (y == BASE_A && (z == BASE_A || z == BASE_G)) return 1'b1;
    return with_tga && y == BASE_G && z == BASE_A;
  endfunction

  task automatic clear_region_state();
    hist_new    = BASE_A;
    hist_old    = BASE_A;
    phase       = PHASE_ZERO;
    codons      = '0;
    opens_atg   = 1'b0;
    prev_stop   = 1'b0;
    stop_inside = 1'b0;
  endtask

  // Advance the predictor by one accepted base; queue a verdict on last.
  task automatic predict_verdict(input logic [BASE_BITS-1:0] base_in, input logic is_first,
                                 input logic is_last, input logic [3:0] flags_in);
    logic [BASE_BITS-1:0] b;
    logic [BASE_BITS-1:0] p_old;
    logic [BASE_BITS-1:0] p_new;
    bit                   tail_stop;
    region_verdict_t      v;
    b = (base_in > BASE_OTHER) ? BASE_OTHER : base_in;
    p_old = hist_old;
    p_new = hist_new;
    if (is_first) begin
      clear_region_state();
      p_old = BASE_A;
      p_new = BASE_A;
      held_flags = flags_in;
    end
    if (phase >= PHASE_TWO) begin
      // a codon completes here
      if (codons == '0) opens_atg = codon_atg(p_old, p_new, b);
      if (prev_stop) stop_inside = 1'b1;
      prev_stop = codon_stop(p_old, p_new, b, (held_flags & RF_SEC) == RF_NONE);
      if (codons != CODON_MAX) codons = codons + CODON_BITS'(1);
      phase = PHASE_ZERO;
    end else begin
      phase = phase + 2'd1;
    end
    tail_stop = is_last && codons != '0 && codon_stop(p_old, p_new, b, 1'b1);
    hist_old = p_new;
    hist_new = b;
    if (is_last) begin
      if (phase != PHASE_ZERO)
        v.verdict = VERDICT_BAD_LENGTH;
      else if ((held_flags & RF_START) != RF_NONE && !opens_atg &&
               (held_flags & RF_ALT) == RF_NONE)
        v.verdict = VERDICT_BAD_START;
      else if (stop_inside)
        v.verdict = VERDICT_INT_STOP;
      else if ((held_flags & RF_END) != RF_NONE && !tail_stop)
        v.verdict = VERDICT_BAD_END;
      else
        v.verdict = VERDICT_OK;
      v.codons     = (codons > OUT_MAX) ? OUT_MAX : OUT_COUNT_BITS'(codons);
      v.begins_atg = codons != '0 && opens_atg;
      v.ends_stop  = tail_stop;
      pending_verdicts.push_back(v);
      clear_region_state();
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitors: requests feed the predictor, results are checked in order
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      predict_verdict(in_base, in_first, in_last,
                      {in_alt_start_ok, in_selenocysteine, in_end_complete,
                       in_start_complete});
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing pending, verdict", out_verdict, 0);
      end else begin
        head = pending_verdicts.pop_front();
        if (out_verdict !== head.verdict)
          report_mismatch("verdict", out_verdict, head.verdict);
        if (out_codon_count !== head.codons)
          report_mismatch("codon_count", out_codon_count, head.codons);
        if (out_begins_atg !== head.begins_atg)
          report_mismatch("begins_atg", out_begins_atg, head.begins_atg);
        if (out_ends_stop !== head.ends_stop)
          report_mismatch("ends_stop", out_ends_stop, head.ends_stop);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: out_ready changes at the falling edge; outside a hold-off, one update per edge
  // ---------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_req) begin
        // long hold-off: the result register fills and in_ready drops
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_ready <= 1'b1;
          RX_RANDOM:  out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
          RX_PATTERN: out_ready <= ((rx_tick % rx_period) < rx_open);
          default:    out_ready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  // Offer one base and wait for its handshake; gaps fall between bursts.
  task automatic send_base(input logic [BASE_BITS-1:0] b, input logic is_first,
                           input logic is_last, input logic [3:0] flags);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_base           <= b;
    in_first          <= is_first;
    in_last           <= is_last;
    in_start_complete <= flags[0];
    in_end_complete   <= flags[1];
    in_selenocysteine <= flags[2];
    in_alt_start_ok   <= flags[3];
    do @(posedge clk); while (!in_ready);
  endtask

  // Send a region; flag ports carry noise on every base that is not marked first.
  task automatic send_region(input base_seq_t bases, input logic [3:0] flags,
                             input bit with_first, input bit with_last);
    logic is_first;
    logic is_last;
    for (int i = 0; i < bases.size(); i++) begin
      is_first = with_first && i == 0;
      is_last  = with_last && i == bases.size() - 1;
      send_base(bases[i], is_first, is_last, is_first ? flags : 4'($urandom));
    end
  endtask

  // Mostly a/c/g/t, now and then one of the other codes.
  function automatic logic [BASE_BITS-1:0] random_base();
    if ($urandom_range(0, 7) == 0)
      return BASE_BITS'($urandom_range(BASE_OTHER, BASE_CODE_MAX));
    return BASE_BITS'($urandom_range(BASE_A, BASE_T));
  endfunction

  function automatic logic [3*BASE_BITS-1:0] stop_codon();
    case ($urandom_range(0, 2))
      0:       return {BASE_T, BASE_A, BASE_A};
      1:       return {BASE_T, BASE_A, BASE_G};
      default: return {BASE_T, BASE_G, BASE_A};
    endcase
  endfunction

  function automatic logic [3*BASE_BITS-1:0] random_codon();
    if ($urandom_range(0, 9) == 0) return stop_codon();
    return {random_base(), random_base(), random_base()};
  endfunction

  function automatic void push_codon(ref base_seq_t q, input logic [3*BASE_BITS-1:0] c);
    q.push_back(c[8:6]);
    q.push_back(c[5:3]);
    q.push_back(c[2:0]);
  endfunction

  // Random regions until about n_items bases went out. Most are framed
  // reading frames (atg ... stop with random codons), the rest are off-frame
  // lengths, raw noise and regions with a missing first or last.
  task automatic send_random_regions(input int n_items);
    base_seq_t  bases;
    int         sent;
    int         kind;
    int         n_codons;
    bit         with_first;
    bit         with_last;
    sent = 0;
    while (sent < n_items) begin
      bases.delete();
      with_first = 1'b1;
      with_last  = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // a few long regions, mostly short ones
        n_codons = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 50)
                                                 : $urandom_range(1, 6);
        for (int i = 0; i < n_codons; i++) begin
          if (i == 0 && $urandom_range(0, 9) < 6)
            push_codon(bases, {BASE_A, BASE_T, BASE_G});
          else if (i == n_codons - 1 && $urandom_range(0, 9) < 6)
            push_codon(bases, stop_codon());
          else
            push_codon(bases, random_codon());
        end
        if (kind >= 65) begin
          // shift the length off the frame
          if ($urandom_range(0, 1) == 1 && bases.size() > 1)
            void'(bases.pop_back());
          else
            bases.push_back(random_base());
        end
      end else begin
        repeat ($urandom_range(1, 12)) bases.push_back(random_base());
        if (kind >= 90) begin
          with_first = 1'($urandom_range(0, 1));
          with_last  = 1'($urandom_range(0, 1));
        end
      end
      send_region(bases, 4'($urandom), with_first, with_last);
      sent += bases.size();
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Hand-picked regions, one per check, no idling on either side.
  task automatic test_directed_regions();
    sender_gaps = 1'b0;
    rx_mode     = RX_ALWAYS;
    // one-base region with a code above the other-base code
    send_region('{BASE_CODE_MAX}, RF_ALL, 1'b1, 1'b1);
    // too short for a codon
    send_region('{BASE_A, BASE_T}, RF_START, 1'b1, 1'b1);
    // off the frame, but the last three bases still form taa
    send_region('{BASE_C, BASE_T, BASE_A, BASE_A}, RF_END, 1'b1, 1'b1);
    // non-atg start claimed complete, no alternative allowed
    send_region('{BASE_C, BASE_T, BASE_G}, RF_START, 1'b1, 1'b1);
    // region opened after a last without first keeps the old flags
    send_region('{BASE_C, BASE_T, BASE_G}, RF_ALL, 1'b0, 1'b1);
    // atg only, end claimed complete: bad end
    send_region('{BASE_A, BASE_T, BASE_G}, RF_START | RF_END, 1'b1, 1'b1);
    // tga inside with selenocysteine, closing taa: passes
    send_region('{BASE_T, BASE_G, BASE_A, BASE_T, BASE_A, BASE_A},
                RF_END | RF_SEC, 1'b1, 1'b1);
    // tga inside without selenocysteine; alternative start covers the non-atg start
    send_region('{BASE_T, BASE_G, BASE_A, BASE_C, BASE_C, BASE_C},
                RF_START | RF_ALT, 1'b1, 1'b1);
  endtask

  // Random regions with input bursts and random result stalls.
  task automatic test_random_flow();
    sender_gaps  = 1'b1;
    rx_mode      = RX_RANDOM;
    rx_stall_pct = 30;
    send_random_regions(280);
  endtask

  // The receiver holds off for a long stretch while bases keep coming.
  task automatic test_back_pressure();
    base_seq_t codon_atg_seq;
    codon_atg_seq = '{BASE_A, BASE_T, BASE_G};
    sender_gaps = 1'b0;
    rx_mode     = RX_ALWAYS;
    hold_req    = 1'b1;
    repeat (40) send_region(codon_atg_seq, 4'($urandom), 1'b1, 1'b1);
    wait (hold_req == 1'b0);
  endtask

  // Heavy stalls on a fixed pattern, then a stretch with no idling at all.
  task automatic test_stall_pattern();
    sender_gaps = 1'b1;
    rx_mode     = RX_PATTERN;
    rx_period   = 9;
    rx_open     = 2;
    send_random_regions(220);
    sender_gaps = 1'b0;
    rx_mode     = RX_ALWAYS;
    send_random_regions(130);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_base           = BASE_A;
    in_first          = 1'b0;
    in_last           = 1'b0;
    in_start_complete = 1'b0;
    in_end_complete   = 1'b0;
    in_selenocysteine = 1'b0;
    in_alt_start_ok   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_regions();
    test_random_flow();
    test_back_pressure();
    test_stall_pattern();

    // stop offering, let the receiver drain what is still in flight
    @(negedge clk);
    in_valid <= 1'b0;
    rx_mode = RX_ALWAYS;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
